// File: src/signed_integer_to_radix_text_assert.svh
// Assertion macros for the signed integer to radix text block.
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_ASSERT_SVH

`ifndef SYNTHESIS

// Implication in the same cycle, checked outside reset
`define SIRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle, checked outside reset
`define SIRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SIRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SIRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/sirt_pkg.sv
// Types, character codes and digit encoding for the radix text converter.
package sirt_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT
    } t_state;

    typedef logic [5:0] t_digit;
    typedef logic [6:0] t_char;

    localparam t_char  CHAR_ZERO    = 7'h30;
    localparam t_char  CHAR_MINUS   = 7'h2D;
    localparam t_char  CHAR_LOWER_A = 7'h61;
    localparam t_digit RADIX_RESET  = 6'd10;
    localparam t_digit RADIX_MIN    = 6'd2;
    localparam t_digit RADIX_MAX    = 6'd36;
    localparam t_digit DIGIT_TEN    = 6'd10;

    // Map a digit value to its ASCII code
    function automatic t_char digit_char(input t_digit d);
        t_char c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + {1'b0, d};
        end else begin
            c = CHAR_LOWER_A + {1'b0, d - DIGIT_TEN};
        end
        return c;
    endfunction

    // Clamp the programmed base into the supported range
    function automatic t_digit clamp_radix(input t_digit r);
        t_digit e;
        if (r < RADIX_MIN) begin
            e = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            e = RADIX_MAX;
        end else begin
            e = r;
        end
        return e;
    endfunction

endpackage

// File: src/signed_integer_to_radix_text.sv
// Signed integer to ASCII text converter in a programmable base.
//
// Input channel (i_valid, o_stall, i_value): one signed value per transfer.
// Output channel (o_valid, i_stall, o_character, o_last): one ASCII character
// per transfer, most significant first; a '-' leads any negative value and
// o_last marks the final character of the run.
// i_cfg_wen / i_cfg_wdata write the base (2..36, clamped); write only while idle.
//
// Each digit is produced by a bit-serial restoring divider that shifts the
// magnitude through one bit per cycle, over all VALUE_WIDTH bits per digit.
// Digits are kept in a small digit store and read back in reverse order.
// One value is converted at a time; the next value is taken once the last
// character has entered the output register.
// Reset returns the base to 10 and empties the pipeline; a stalled receiver
// holds the output register and the converter waits for it.
module signed_integer_to_radix_text #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [5:0]             i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [6:0]             o_character,
    output logic                   o_last
);

    import sirt_pkg::*;

    `include "signed_integer_to_radix_text_assert.svh"

    localparam int BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    t_state r_state, n_state;

    t_digit                r_radix;
    t_digit                r_radix_eff;
    logic                  r_neg;
    logic [VALUE_WIDTH-1:0] r_mag;
    t_digit                r_rem;
    logic [BW-1:0]         r_bit;
    logic [CW-1:0]         r_count;
    t_digit                r_rd_data;
    logic                  r_out_valid;
    t_char                 r_char;
    logic                  r_last;

    t_digit digit_mem [VALUE_WIDTH];

    logic                   in_xfer;
    logic                   out_free;
    logic                   out_load;
    t_char                  load_char;
    logic                   load_last;
    logic [6:0]             trial;
    logic                   ge;
    logic [6:0]             diff;
    t_digit                 rem_next;
    logic [VALUE_WIDTH-1:0] quot_next;
    logic                   bit_end;
    logic                   quot_zero;
    logic [VALUE_WIDTH-1:0] in_mag;

    // Divider datapath: one restoring step per cycle
    assign trial     = {r_rem, r_mag[VALUE_WIDTH-1]};
    assign ge        = (trial >= {1'b0, r_radix_eff});
    assign diff      = trial - {1'b0, r_radix_eff};
    assign rem_next  = ge ? diff[5:0] : trial[5:0];
    assign quot_next = {r_mag[VALUE_WIDTH-2:0], ge};
    assign bit_end   = (r_bit == BW'(VALUE_WIDTH - 1));
    assign quot_zero = (quot_next == '0);
    assign in_mag    = i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;

    assign out_free = !r_out_valid || !i_stall;
    assign in_xfer  = i_valid && !o_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (bit_end && quot_zero) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                if (!r_neg || out_free) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = (r_count == '0) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_stall   = 1'b1;
        out_load  = 1'b0;
        load_char = CHAR_MINUS;
        load_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
            end
            S_SIGN: begin
                out_load = r_neg && out_free;
            end
            S_EMIT: begin
                out_load  = out_free;
                load_char = digit_char(r_rd_data);
                load_last = (r_count == '0);
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // Hold state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_radix <= RADIX_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                r_radix <= i_cfg_wdata;
            end
        end
    end

    // Advance the divider and the digit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_xfer) begin
            r_count <= '0;
        end else if (r_state == S_DIV && bit_end) begin
            r_count <= r_count + 1'b1;
        end else if (r_state == S_READ) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_neg       <= i_value[VALUE_WIDTH-1];
            r_mag       <= in_mag;
            r_radix_eff <= clamp_radix(r_radix);
            r_rem       <= '0;
            r_bit       <= '0;
        end else if (r_state == S_DIV) begin
            r_mag <= quot_next;
            if (bit_end) begin
                r_rem <= '0;
                r_bit <= '0;
            end else begin
                r_rem <= rem_next;
                r_bit <= r_bit + 1'b1;
            end
        end
    end

    // Digit store: write each finished digit, read back in reverse
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && bit_end) begin
            digit_mem[r_count[BW-1:0]] <= rem_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_data <= digit_mem[r_count[BW-1:0] - 1'b1];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_char <= load_char;
            r_last <= load_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    `SIRT_ASSERT_NXT(a_accept_starts_div, i_clk, i_rst_n,
        in_xfer, r_state == S_DIV, "transfer in did not start division")
    `SIRT_ASSERT_IMP(a_rem_below_radix, i_clk, i_rst_n,
        r_state == S_DIV, r_rem < r_radix_eff, "remainder not below base")
    `SIRT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n,
        1'b1, r_count <= CW'(VALUE_WIDTH), "digit count beyond value width")
    `SIRT_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n,
        out_load && r_out_valid, !i_stall, "output register overwritten while stalled")

endmodule
